### hw/rtl/wcr_pkg.sv
`default_nettype none

package wcr_pkg;

    // panel geometry
    localparam int NUM_PAGES = 8;

    // command bytes
    localparam logic [7:0] CMD_PAGE_ADDR = 8'hB0;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;
    localparam logic [7:0] MASK_FULL     = 8'hFF;
    localparam logic [7:0] MASK_EMPTY    = 8'h00;

    // position of a byte within one page write
    localparam logic [1:0] BYTE_PAGE   = 2'd0;
    localparam logic [1:0] BYTE_COL_LO = 2'd1;
    localparam logic [1:0] BYTE_COL_HI = 2'd2;
    localparam logic [1:0] BYTE_DATA   = 2'd3;

    // one classified sample, ready for the byte sequencer
    typedef struct packed {
        logic [6:0] col;       // column of the trace run
        logic [6:0] next_col;  // column that gets blanked
        logic [2:0] hi_page;   // first page written
        logic [2:0] lo_page;   // last page written
        logic [7:0] hi_data;   // data for the first page
        logic [7:0] lo_data;   // data for the last page (pages between get all ones)
    } job_t;

endpackage

`default_nettype wire

### hw/rtl/waveform_column_renderer.sv
`default_nettype none

// Waveform column renderer. Each input beat is one sample (column, height
// 0..63); the block emits the byte stream for a page-addressed, 8-page
// monochrome panel that draws a vertical run joining the previous height to
// this one, then blanks all 8 pages of the next column (wrapping at COLUMNS).
// Every page write is three command beats then one data beat (tuser high).
// A sample produces 36 to 64 output beats, one per cycle while the sink is
// ready, so the output channel sets the rate. Input beats are classified on
// accept and held in a two-entry queue, so the source is stalled only when
// that queue is full.
module waveform_column_renderer
    import wcr_pkg::*;
#(
    parameter int COLUMNS = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // column[6:0], sample[12:7], zero[15:13]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // bus_byte[7:0]
    output logic             m_tuser,   // is_data
    output logic             m_tlast
);

    job_t new_job;
    job_t head_job;
    logic accept;
    logic full;
    logic head_valid;
    logic pop;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    wcr_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .column (s_tdata[6:0]),
        .sample (s_tdata[12:7]),
        .job    (new_job)
    );

    wcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_job   (new_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    wcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/wcr_front.sv
`default_nettype none

module wcr_front
    import wcr_pkg::*;
#(
    parameter int COLUMNS = 128
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [6:0] column,
    input  wire logic [5:0] sample,
    output job_t            job
);

    logic [2:0] prev_page_reg, prev_page_next;
    logic [2:0] prev_bit_reg, prev_bit_next;
    logic [7:0] prev_mask_reg, prev_mask_next;

    logic [2:0] cur_page;
    logic [2:0] cur_bit;
    logic [7:0] cur_mask;
    logic [7:0] full_shl_prev;
    logic [7:0] col_inc;

    // height to page / bit position
    assign cur_page      = ~sample[5:3];
    assign cur_bit       = ~sample[2:0];
    assign cur_mask      = 8'd1 << cur_bit;
    assign full_shl_prev = MASK_FULL << prev_bit_reg;
    assign col_inc       = {1'b0, column} + 8'd1;

    // classify the run against the previous sample
    always_comb
    begin
        job.col      = column;
        job.next_col = (col_inc >= 8'(COLUMNS)) ? 7'd0 : col_inc[6:0];
        if (prev_page_reg > cur_page)
        begin
            job.hi_page = prev_page_reg;
            job.lo_page = cur_page;
            job.hi_data = prev_mask_reg - 8'd1;
            job.lo_data = MASK_FULL << cur_bit;
        end
        else if (prev_page_reg == cur_page)
        begin
            job.hi_page = cur_page;
            job.lo_page = cur_page;
            if (cur_bit == prev_bit_reg)
                job.hi_data = cur_mask;
            else if (cur_bit > prev_bit_reg)
                job.hi_data = (cur_mask - prev_mask_reg) | cur_mask;
            else
                job.hi_data = prev_mask_reg - cur_mask;
            job.lo_data = job.hi_data;
        end
        else
        begin
            job.hi_page = cur_page;
            job.lo_page = prev_page_reg;
            job.hi_data = {cur_mask[6:0], 1'b0} - 8'd1;
            job.lo_data = {full_shl_prev[6:0], 1'b0};
        end
    end

    // previous sample tracking
    always_comb
    begin
        prev_page_next = prev_page_reg;
        prev_bit_next  = prev_bit_reg;
        prev_mask_next = prev_mask_reg;
        if (accept)
        begin
            prev_page_next = cur_page;
            prev_bit_next  = cur_bit;
            prev_mask_next = cur_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_page_reg <= 3'd0;
            prev_bit_reg  <= 3'd0;
            prev_mask_reg <= 8'd0;
        end
        else
        begin
            prev_page_reg <= prev_page_next;
            prev_bit_reg  <= prev_bit_next;
            prev_mask_reg <= prev_mask_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/wcr_queue.sv
`default_nettype none

module wcr_queue
    import wcr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

### hw/rtl/wcr_back.sv
`default_nettype none

module wcr_back
    import wcr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    input  wire job_t       job,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // bus_byte[7:0]
    output logic            m_tuser,   // is_data
    output logic            m_tlast
);

    localparam logic PH_RUN   = 1'b0;
    localparam logic PH_BLANK = 1'b1;

    logic       phase_reg, phase_next;
    logic       started_reg, started_next;
    logic [2:0] page_reg, page_next;
    logic [1:0] idx_reg, idx_next;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       data_reg, data_next;
    logic       last_reg, last_next;

    logic       fire;
    logic [2:0] page;
    logic [6:0] col;
    logic [7:0] data;
    logic       final_byte;

    assign fire       = job_valid && (!valid_reg || m_tready);
    assign page       = started_reg ? page_reg : job.hi_page;
    assign col        = (phase_reg == PH_BLANK) ? job.next_col : job.col;
    assign final_byte = (phase_reg == PH_BLANK) && (page == 3'(NUM_PAGES - 1))
                        && (idx_reg == BYTE_DATA);
    assign pop        = fire && final_byte;

    // data byte of the current page
    always_comb
    begin
        if (phase_reg == PH_BLANK)
            data = MASK_EMPTY;
        else if (page == job.hi_page)
            data = job.hi_data;
        else if (page == job.lo_page)
            data = job.lo_data;
        else
            data = MASK_FULL;
    end

    // byte sequencer
    always_comb
    begin
        phase_next   = phase_reg;
        started_next = started_reg;
        page_next    = page_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg && !m_tready;
        byte_next    = byte_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        if (fire)
        begin
            valid_next = 1'b1;
            last_next  = final_byte;
            data_next  = (idx_reg == BYTE_DATA);
            case (idx_reg)
                BYTE_PAGE:   byte_next = CMD_PAGE_ADDR | {5'd0, page};
                BYTE_COL_LO: byte_next = {4'd0, col[3:0]};
                BYTE_COL_HI: byte_next = CMD_COL_HI | {5'd0, col[6:4]};
                BYTE_DATA:   byte_next = data;
                default:     byte_next = MASK_EMPTY;
            endcase
            started_next = 1'b1;
            page_next    = page;
            if (idx_reg != BYTE_DATA)
            begin
                idx_next = idx_reg + 2'd1;
            end
            else
            begin
                idx_next = BYTE_PAGE;
                if (phase_reg == PH_RUN)
                begin
                    if (page == job.lo_page)
                    begin
                        phase_next = PH_BLANK;
                        page_next  = 3'd0;
                    end
                    else
                    begin
                        page_next = page - 3'd1;
                    end
                end
                else if (final_byte)
                begin
                    phase_next   = PH_RUN;
                    started_next = 1'b0;
                end
                else
                begin
                    page_next = page + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_RUN;
            started_reg <= 1'b0;
            page_reg    <= 3'd0;
            idx_reg     <= BYTE_PAGE;
            valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            started_reg <= started_next;
            page_reg    <= page_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = data_reg;
    assign m_tlast  = last_reg;

    // a job leaves the queue only with its closing beat
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid && m_tlast))
        else $error("job popped without last beat");

    // every fourth beat of a page write is the data beat
    a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (m_tuser == ($past(idx_reg) == BYTE_DATA)))
        else $error("data flag out of step with byte position");

    // a page write opens with a page address command
    a_page_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && idx_reg == BYTE_PAGE) |=> (m_tdata[7:3] == CMD_PAGE_ADDR[7:3]))
        else $error("page write did not start with page command");

    // blank phase writes only zero data
    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_BLANK && idx_reg == BYTE_DATA)
        |=> (m_tdata == MASK_EMPTY))
        else $error("blanking wrote nonzero data");

endmodule

`default_nettype wire
